FILE: sv/bas_pkg.sv
// Shared types, constants and digit arithmetic for the BCD add/subtract core.
package bas_pkg;

  localparam int DIGITS    = 8;
  localparam int NUM_DIG   = DIGITS + 1;
  localparam int VEC_W     = 4 * NUM_DIG;
  localparam int OPND_W    = 32;
  localparam int MAG_W     = 36;
  localparam int SEG_DIG   = 3;
  localparam int NUM_SEG   = (NUM_DIG + SEG_DIG - 1) / SEG_DIG;

  localparam logic [3:0] DEC_MAX = 4'd9;
  localparam logic [4:0] DEC_ADJ = 5'd6;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_SUB = 1'b1
  } cmd_e;

  typedef logic [VEC_W-1:0] vec_t;
  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic sub;
    logic neg;
    logic bad;
    vec_t keep;
  } tag_t;

  typedef struct packed {
    logic c;
    vec_t s;
  } seg_res_t;

  function automatic logic [4:0] dec_digit(logic [3:0] x, logic [3:0] y, logic cin);
    logic [4:0] raw;
    logic [4:0] adj;
    logic [4:0] r;
    raw = {1'b0, x} + {1'b0, y} + {4'b0000, cin};
    adj = {1'b0, raw[3:0]} + DEC_ADJ;
    if ((raw[3:0] > DEC_MAX) || raw[4]) begin
      r = {adj[4] | raw[4], adj[3:0]};
    end else begin
      r = {1'b0, raw[3:0]};
    end
    return r;
  endfunction

  function automatic seg_res_t seg_add(vec_t x, vec_t y, vec_t s_in, logic cin, int k);
    seg_res_t   r;
    logic [4:0] d;
    int         idx;
    r.s = s_in;
    r.c = cin;
    for (int i = 0; i < SEG_DIG; i++) begin
      idx = k * SEG_DIG + i;
      if (idx < NUM_DIG) begin
        d = dec_digit(x[4*idx +: 4], y[4*idx +: 4], r.c);
        r.s[4*idx +: 4] = d[3:0];
        r.c = d[4];
      end
    end
    return r;
  endfunction

  function automatic vec_t nines(vec_t v);
    vec_t r;
    for (int i = 0; i < NUM_DIG; i++) begin
      r[4*i +: 4] = DEC_MAX - v[4*i +: 4];
    end
    return r;
  endfunction

  function automatic vec_t widen(logic [OPND_W-1:0] op);
    vec_t r;
    r = '0;
    for (int j = 0; j < 4 * DIGITS; j++) begin
      if (j < OPND_W) begin
        r[j] = op[j];
      end
    end
    return r;
  endfunction

  function automatic mag_t to_mag(vec_t v);
    mag_t r;
    r = '0;
    for (int j = 0; j < MAG_W; j++) begin
      if (j < VEC_W) begin
        r[j] = v[j];
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/bcd_add_subtract_core.sv
// Pipelined packed-BCD adder/subtractor with ten's complement recovery of negative differences.
// One transfer is accepted per clock and results leave in order, one per clock,
// while the output is not stalled. One stage widens the operands, checks the digits
// and forms the nine's complement of the subtrahend; three stages ripple the sum
// three digits each; three more stages form the ten's complement of a negative
// difference. Stalls on the output hold the pipeline and empty stages fill up
// before the input side is stalled. Magnitude is DIGITS+1 BCD digits; negative
// marks a subtraction whose result is below zero; invalid_digit marks any operand
// nibble above nine, and the raw nibbles are still summed.
module bcd_add_subtract_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [bas_pkg::OPND_W-1:0] operand_a_i,
  input  logic [bas_pkg::OPND_W-1:0] operand_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bas_pkg::MAG_W-1:0]  magnitude_o,
  output logic                       negative_o,
  output logic                       invalid_digit_o
);
  import bas_pkg::*;

  logic p_valid, p_ready, p_cin;
  vec_t p_x, p_y;
  tag_t p_tag;

  logic r1_valid, r1_ready, r1_cout;
  vec_t r1_sum;
  tag_t r1_tag;

  logic r2_in_ready;
  vec_t c_x, c_y;
  tag_t c_tag;

  logic r2_cout;
  vec_t r2_sum;
  tag_t r2_tag;
  logic in_ready;

  bas_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .x_o         (p_x),
    .y_o         (p_y),
    .cin_o       (p_cin),
    .tag_o       (p_tag)
  );

  bas_ripple u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .x_i         (p_x),
    .y_i         (p_y),
    .cin_i       (p_cin),
    .tag_i       (p_tag),
    .out_valid_o (r1_valid),
    .out_ready_i (r1_ready),
    .sum_o       (r1_sum),
    .cout_o      (r1_cout),
    .tag_o       (r1_tag)
  );

  always_comb begin
    c_x        = nines(r1_sum);
    c_y        = vec_t'(1);
    c_tag      = r1_tag;
    c_tag.neg  = r1_tag.sub && !r1_cout;
    c_tag.keep = r1_sum;
  end

  assign r1_ready = r2_in_ready;

  bas_ripple u_recomp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (r1_valid),
    .in_ready_o  (r2_in_ready),
    .x_i         (c_x),
    .y_i         (c_y),
    .cin_i       (1'b0),
    .tag_i       (c_tag),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .sum_o       (r2_sum),
    .cout_o      (r2_cout),
    .tag_o       (r2_tag)
  );

  assign in_stall_o      = !in_ready;
  assign magnitude_o     = to_mag(r2_tag.neg ? r2_sum : r2_tag.keep);
  assign negative_o      = r2_tag.neg;
  assign invalid_digit_o = r2_tag.bad;

`ifndef ASSERT_OFF
  a_neg_from_sub : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && negative_o |-> r2_tag.sub)
    else $error("negative result flagged for an addition");
  a_no_stall_when_draining : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled although the output drains");
  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(magnitude_o)
      && $stable(negative_o) && $stable(invalid_digit_o))
    else $error("stalled result changed");
  a_unused_carry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && negative_o && (r2_tag.keep != '0) |-> !r2_cout)
    else $error("recomplement of a nonzero difference carried out");
`endif

endmodule

FILE: sv/bas_prep.sv
// Operand widening, digit check and subtrahend complement register stage.
module bas_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [bas_pkg::OPND_W-1:0]  operand_a_i,
  input  logic [bas_pkg::OPND_W-1:0]  operand_b_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bas_pkg::vec_t               x_o,
  output bas_pkg::vec_t               y_o,
  output logic                        cin_o,
  output bas_pkg::tag_t               tag_o
);
  import bas_pkg::*;

  logic valid_q;
  logic en;
  vec_t a_w, b_w;
  vec_t x_d, y_d, x_q, y_q;
  logic cin_d, cin_q;
  tag_t tag_d, tag_q;
  logic bad;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    a_w = widen(operand_a_i);
    b_w = widen(operand_b_i);
    bad = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if ((a_w[4*i +: 4] > DEC_MAX) || (b_w[4*i +: 4] > DEC_MAX)) begin
        bad = 1'b1;
      end
    end
    x_d      = a_w;
    y_d      = (cmd_e'(cmd_i) == CMD_SUB) ? nines(b_w) : b_w;
    cin_d    = (cmd_e'(cmd_i) == CMD_SUB);
    tag_d    = '0;
    tag_d.sub = cin_d;
    tag_d.bad = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      cin_q <= cin_d;
      tag_q <= tag_d;
    end
  end

  assign out_valid_o = valid_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign cin_o       = cin_q;
  assign tag_o       = tag_q;

endmodule

FILE: sv/bas_ripple.sv
// Pipelined decimal ripple adder, SEG_DIG (three) digits per register stage.
module bas_ripple (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bas_pkg::vec_t x_i,
  input  bas_pkg::vec_t y_i,
  input  logic          cin_i,
  input  bas_pkg::tag_t tag_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bas_pkg::vec_t sum_o,
  output logic          cout_o,
  output bas_pkg::tag_t tag_o
);
  import bas_pkg::*;

  logic [NUM_SEG-1:0] v_q;
  logic [NUM_SEG:0]   en;
  vec_t               x_q   [NUM_SEG];
  vec_t               y_q   [NUM_SEG];
  vec_t               s_q   [NUM_SEG];
  logic               c_q   [NUM_SEG];
  tag_t               tag_q [NUM_SEG];

  assign en[NUM_SEG] = out_ready_i;

  for (genvar k = 0; k < NUM_SEG; k++) begin : g_seg
    logic     v_in;
    vec_t     x_in, y_in, s_in;
    logic     c_in;
    tag_t     t_in;
    seg_res_t res;

    if (k == 0) begin : g_first
      assign v_in = in_valid_i;
      assign x_in = x_i;
      assign y_in = y_i;
      assign s_in = '0;
      assign c_in = cin_i;
      assign t_in = tag_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign s_in = s_q[k-1];
      assign c_in = c_q[k-1];
      assign t_in = tag_q[k-1];
    end

    assign en[k] = !v_q[k] || en[k+1];
    assign res   = seg_add(x_in, y_in, s_in, c_in, k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && v_in) begin
        x_q[k]   <= x_in;
        y_q[k]   <= y_in;
        s_q[k]   <= res.s;
        c_q[k]   <= res.c;
        tag_q[k] <= t_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NUM_SEG-1];
  assign sum_o       = s_q[NUM_SEG-1];
  assign cout_o      = c_q[NUM_SEG-1];
  assign tag_o       = tag_q[NUM_SEG-1];

`ifndef ASSERT_OFF
  a_hold_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NUM_SEG-1] && !out_ready_i |=> v_q[NUM_SEG-1] && $stable(s_q[NUM_SEG-1])
      && $stable(c_q[NUM_SEG-1]))
    else $error("held result changed while stalled");
  a_ready_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("pipeline stalled although the output drains");
`endif

endmodule

FILE: dv/bcd_result_tracker_pkg.sv
// Expected-result tracking for the packed-BCD add/subtract core: decimal prediction and comparison.
package bcd_result_tracker_pkg;

  import bas_pkg::*;

  typedef struct {
    cmd_e              op;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    mag_t              magnitude;
    logic              negative;
    logic              invalid_digit;
  } bcd_sum_t;

  class bcd_result_tracker;

    bcd_sum_t awaited_sums[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [VEC_W:0] ripple(vec_t x, vec_t y, logic cin);
      vec_t       s;
      logic       c;
      logic [4:0] raw;
      logic [4:0] adj;
      s = '0;
      c = cin;
      for (int i = 0; i < NUM_DIG; i++) begin
        raw = {1'b0, x[4*i +: 4]} + {1'b0, y[4*i +: 4]} + {4'b0000, c};
        if ((raw[3:0] > DEC_MAX) || raw[4]) begin
          adj = {1'b0, raw[3:0]} + DEC_ADJ;
          s[4*i +: 4] = adj[3:0];
          c = adj[4] | raw[4];
        end else begin
          s[4*i +: 4] = raw[3:0];
          c = 1'b0;
        end
      end
      return {c, s};
    endfunction

    function vec_t nines_of(vec_t v);
      vec_t r;
      for (int i = 0; i < NUM_DIG; i++) begin
        r[4*i +: 4] = DEC_MAX - v[4*i +: 4];
      end
      return r;
    endfunction

    function bcd_sum_t decimal_result(cmd_e op, logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
      bcd_sum_t       e;
      vec_t           wa;
      vec_t           wb;
      vec_t           one;
      logic [VEC_W:0] r;
      e.op = op;
      e.a = a;
      e.b = b;
      e.negative = 1'b0;
      e.invalid_digit = 1'b0;
      wa = '0;
      wb = '0;
      one = '0;
      one[0] = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
        wa[4*i +: 4] = a[4*i +: 4];
        wb[4*i +: 4] = b[4*i +: 4];
        if ((a[4*i +: 4] > DEC_MAX) || (b[4*i +: 4] > DEC_MAX)) begin
          e.invalid_digit = 1'b1;
        end
      end
      if (op == CMD_ADD) begin
        r = ripple(wa, wb, 1'b0);
      end else begin
        r = ripple(wa, nines_of(wb), 1'b1);
        if (!r[VEC_W]) begin
          e.negative = 1'b1;
          r = ripple(nines_of(r[VEC_W-1:0]), one, 1'b0);
        end
      end
      e.magnitude = r[MAG_W-1:0];
      return e;
    endfunction

    function void note_operands(cmd_e op, logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
      awaited_sums.push_back(decimal_result(op, a, b));
    endfunction

    function void check_result(mag_t magnitude, logic negative, logic invalid_digit);
      bcd_sum_t e;
      if (awaited_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: magnitude %h negative %b invalid_digit %b",
                   magnitude, negative, invalid_digit);
        end
        return;
      end
      e = awaited_sums.pop_front();
      if ((magnitude !== e.magnitude) || (negative !== e.negative) ||
          (invalid_digit !== e.invalid_digit)) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch for %s a %h b %h: expected %h/%b/%b, got %h/%b/%b",
                   e.op.name(), e.a, e.b, e.magnitude, e.negative, e.invalid_digit,
                   magnitude, negative, invalid_digit);
        end
      end
    endfunction

    function int pending();
      return awaited_sums.size();
    endfunction

    function void note_leftovers();
      if (awaited_sums.size() != 0) begin
        mismatches++;
        $display("%0d expected results never arrived", awaited_sums.size());
      end
    endfunction

  endclass

endpackage

FILE: dv/bcd_add_subtract_core_test.sv
// Top-level test for the packed-BCD add/subtract core: directed and random transfers under stalls.
module bcd_add_subtract_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  import bas_pkg::*;
  import bcd_result_tracker_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              cmd_i;
  logic [OPND_W-1:0] operand_a_i;
  logic [OPND_W-1:0] operand_b_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [MAG_W-1:0]  magnitude_o;
  logic              negative_o;
  logic              invalid_digit_o;

  bcd_result_tracker sums = new();
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;

  bcd_add_subtract_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .operand_a_i     (operand_a_i),
    .operand_b_i     (operand_b_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .magnitude_o     (magnitude_o),
    .negative_o      (negative_o),
    .invalid_digit_o (invalid_digit_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sums.check_result(magnitude_o, negative_o, invalid_digit_o);
    end
  end

  task automatic send_op(cmd_e op, logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sums.note_operands(op, a, b);
    @(negedge clk_i);
  endtask

  function automatic logic [OPND_W-1:0] bcd_digits(int unsigned n);
    logic [OPND_W-1:0] r;
    r = '0;
    for (int i = 0; i < n; i++) begin
      r[4*i +: 4] = 4'($urandom_range(9));
    end
    return r;
  endfunction

  function automatic logic [OPND_W-1:0] pick_operand();
    logic [OPND_W-1:0] r;
    case ($urandom_range(9))
      0: r = $urandom();
      1: r = 32'h9999_9999;
      2: r = '0;
      3: begin
        r = bcd_digits(DIGITS);
        r[4*$urandom_range(DIGITS-1) +: 4] = 4'($urandom_range(15, 10));
      end
      default: r = bcd_digits($urandom_range(DIGITS, 1));
    endcase
    return r;
  endfunction

  task automatic run_random(int unsigned count);
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    cmd_e              op;
    for (int k = 0; k < count; k++) begin
      op = $urandom_range(1) ? CMD_SUB : CMD_ADD;
      a  = pick_operand();
      case ($urandom_range(7))
        0: b = a;
        1: begin
          b = a;
          b[4*$urandom_range(DIGITS-1) +: 4] = 4'($urandom_range(9));
        end
        default: b = pick_operand();
      endcase
      send_op(op, a, b);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_ADD;
    operand_a_i    = '0;
    operand_b_i    = '0;
    out_stall_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    send_op(CMD_ADD, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_ADD, 32'h9999_9999, 32'h9999_9999);
    send_op(CMD_ADD, 32'h9999_9999, 32'h0000_0001);
    send_op(CMD_ADD, 32'h4545_4545, 32'h5555_5555);
    send_op(CMD_SUB, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_SUB, 32'h0000_0000, 32'h0000_0001);
    send_op(CMD_SUB, 32'h0000_0001, 32'h0000_0000);
    send_op(CMD_SUB, 32'h1234_5678, 32'h1234_5678);
    send_op(CMD_SUB, 32'h0000_0000, 32'h9999_9999);
    send_op(CMD_SUB, 32'h9999_9999, 32'h0000_0000);
    send_op(CMD_SUB, 32'h5000_0000, 32'h5000_0001);
    send_op(CMD_SUB, 32'h1000_0000, 32'h9999_9999);
    send_op(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(CMD_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(CMD_SUB, 32'h0000_0000, 32'hAAAA_AAAA);
    send_op(CMD_ADD, 32'h0000_000A, 32'h0000_0000);
    send_op(CMD_ADD, 32'h0000_0000, 32'hA000_0000);
    send_op(CMD_SUB, 32'h1234_567F, 32'h0000_0000);
    send_op(CMD_SUB, 32'h0000_0000, 32'hF000_0000);

    run_random(463);
    send_idle_pct = 77;
    run_random(463);
    send_idle_pct  = 0;
    recv_stall_pct = 77;
    run_random(463);
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    run_random(463);

    in_valid_i <= 1'b0;
    while (sums.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    sums.note_leftovers();
    if (sums.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
